// ===== hw/rtl/rdbm_pkg.sv =====
`default_nettype none

package rdbm_pkg;

    localparam int LVL_W         = 16;
    localparam int LOG_FRAC_BITS = 16;
    localparam int K_W           = $clog2(LOG_FRAC_BITS);
    localparam int MANT_W        = 31;
    localparam int NORM_STEP     = 8;

    localparam int DB_W = 34;
    localparam logic [DB_W-1:0] DB_PER_OCT = 34'd12929139865;
    localparam int DB_FRAC_SHIFT = 32;

    localparam int DB_OFFSET = 43 * 65536;
    localparam int DB_SPAN   = 40 * 65536;

    // The level numerator n is below DB_SPAN here, so it fits in N_LO_W bits.
    localparam int N_LO_W      = 22;
    localparam int X_W         = N_LO_W + LVL_W;
    localparam int SCALE_SHIFT = 19;
    localparam int Y_W         = X_W - SCALE_SHIFT;

    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP5 = 22'd3355444;
    localparam int RECIP_SHIFT = 24;
    localparam int Q_W         = Y_W + RECIP_W;

    typedef enum logic [1:0] {
        SEL_CNT   = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2
    } t_sel;

    typedef struct packed {
        t_sel sel;
        logic load;
        logic norm;
        logic iter;
        logic store;
        logic mul;
        logic scale;
        logic recip;
        logic save;
        logic copy;
        logic out_load;
        logic release_snap;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic iter_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/rms_dbfs_level_meter.sv =====
// Throughput: one frame item per cycle; only a window-end item can be held off, and only
// while the levels of the previous window are still being computed or waiting to be taken.
// The result comes from the shared log2 unit (normalize steps, then 16 squaring steps per log),
// run in turn for count and left, and for right unless mono mode copies the left level.
// Reset (synchronous, active low) clears the sums, frame count, mono mode and all handshakes.
`default_nettype none

module rms_dbfs_level_meter #(
    parameter int MAX_WINDOW_FRAMES = 65536,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic [SAMPLE_BITS-1:0]     i_right_sample,
    input  logic                       i_window_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rdbm_pkg::LVL_W-1:0] o_left_level,
    output logic [rdbm_pkg::LVL_W-1:0] o_right_level,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_data
);

    import rdbm_pkg::*;

    localparam int SUM_RAW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW_FRAMES);
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int CNT_W   = $clog2(MAX_WINDOW_FRAMES + 1);

    logic             r_mono;
    logic             w_snap_full;
    logic             w_snap_mono;
    logic [SUM_W-1:0] w_sum_l;
    logic [SUM_W-1:0] w_sum_r;
    logic [CNT_W-1:0] w_cnt;
    t_cmd             w_cmd;
    t_dp_sts          w_dp_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mono <= i_cfg_data;
        end
    end

    rdbm_accum #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES),
        .SUM_W             (SUM_W),
        .CNT_W             (CNT_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_left      (i_left_sample),
        .i_right     (i_right_sample),
        .i_end       (i_window_end),
        .i_mono      (r_mono),
        .i_release   (w_cmd.release_snap),
        .o_stall     (o_in_stall),
        .o_snap_full (w_snap_full),
        .o_snap_mono (w_snap_mono),
        .o_sum_l     (w_sum_l),
        .o_sum_r     (w_sum_r),
        .o_cnt       (w_cnt)
    );

    rdbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_full (w_snap_full),
        .i_snap_mono (w_snap_mono),
        .i_dp_sts    (w_dp_sts),
        .o_cmd       (w_cmd)
    );

    rdbm_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sum_l       (w_sum_l),
        .i_sum_r       (w_sum_r),
        .i_cnt         (w_cnt),
        .i_out_stall   (i_out_stall),
        .o_sts         (w_dp_sts),
        .o_valid       (o_out_valid),
        .o_left_level  (o_left_level),
        .o_right_level (o_right_level)
    );

`ifndef NO_ASSERTIONS
    a_end_reaches_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_window_end) |=> ##1 w_snap_full)
        else $error("window-end item did not reach the snapshot");

    a_no_overwrite_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result register loaded while a stalled result is pending");

    a_release_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.release_snap |-> w_snap_full)
        else $error("snapshot released while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rdbm_accum.sv =====
`default_nettype none

module rdbm_accum #(
    parameter int SAMPLE_BITS       = 16,
    parameter int MAX_WINDOW_FRAMES = 65536,
    parameter int SUM_W             = 47,
    parameter int CNT_W             = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_left,
    input  logic [SAMPLE_BITS-1:0] i_right,
    input  logic                   i_end,
    input  logic                   i_mono,
    input  logic                   i_release,
    output logic                   o_stall,
    output logic                   o_snap_full,
    output logic                   o_snap_mono,
    output logic [SUM_W-1:0]       o_sum_l,
    output logic [SUM_W-1:0]       o_sum_r,
    output logic [CNT_W-1:0]       o_cnt
);

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_FRAMES);

    logic                     accept;
    logic [SAMPLE_BITS-1:0]   mag_l;
    logic [SAMPLE_BITS-1:0]   mag_r;
    logic [2*SAMPLE_BITS-1:0] sq_l;
    logic [2*SAMPLE_BITS-1:0] sq_r;
    logic                     add_en;
    logic [CNT_W-1:0]         cnt_inc;
    logic [SUM_W:0]           add_l;
    logic [SUM_W:0]           add_r;
    logic [SUM_W-1:0]         sum_l_next;
    logic [SUM_W-1:0]         sum_r_next;

    logic                     r_p_valid;
    logic                     r_p_end;
    logic                     r_p_add;
    logic [SQ_W-1:0]          r_p_sq_l;
    logic [SQ_W-1:0]          r_p_sq_r;
    logic [CNT_W-1:0]         r_p_cnt;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [SUM_W-1:0]         r_sum_l;
    logic [SUM_W-1:0]         r_sum_r;
    logic                     r_snap_full;
    logic                     r_snap_mono;
    logic [SUM_W-1:0]         r_snap_l;
    logic [SUM_W-1:0]         r_snap_r;
    logic [CNT_W-1:0]         r_snap_cnt;

    // A window-end item waits while the previous window still owns the snapshot.
    assign o_stall = i_end && (r_snap_full || (r_p_valid && r_p_end));
    assign accept  = i_valid && !o_stall;

    assign mag_l = i_left[SAMPLE_BITS-1]  ? (~i_left + 1'b1)  : i_left;
    assign mag_r = i_right[SAMPLE_BITS-1] ? (~i_right + 1'b1) : i_right;
    assign sq_l  = mag_l * mag_l;
    assign sq_r  = mag_r * mag_r;

    assign add_en  = r_count < CNT_MAX;
    assign cnt_inc = r_count + CNT_W'(add_en);
    assign n_count = i_end ? '0 : cnt_inc;

    assign add_l      = {1'b0, r_sum_l} + (SUM_W+1)'(r_p_sq_l);
    assign add_r      = {1'b0, r_sum_r} + (SUM_W+1)'(r_p_sq_r);
    assign sum_l_next = !r_p_add ? r_sum_l : (add_l[SUM_W] ? '1 : add_l[SUM_W-1:0]);
    assign sum_r_next = !r_p_add ? r_sum_r : (add_r[SUM_W] ? '1 : add_r[SUM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_p_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_end  <= i_end;
            r_p_add  <= add_en;
            r_p_sq_l <= sq_l[SQ_W-1:0];
            r_p_sq_r <= sq_r[SQ_W-1:0];
            r_p_cnt  <= cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_snap_full <= 1'b0;
        end else begin
            if (r_p_valid) begin
                if (r_p_end) begin
                    r_sum_l     <= '0;
                    r_sum_r     <= '0;
                    r_snap_full <= 1'b1;
                end else begin
                    r_sum_l <= sum_l_next;
                    r_sum_r <= sum_r_next;
                end
            end
            if (i_release) begin
                r_snap_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && r_p_end) begin
            r_snap_l    <= sum_l_next;
            r_snap_r    <= sum_r_next;
            r_snap_cnt  <= r_p_cnt;
            r_snap_mono <= i_mono;
        end
    end

    assign o_snap_full = r_snap_full;
    assign o_snap_mono = r_snap_mono;
    assign o_sum_l     = r_snap_l;
    assign o_sum_r     = r_snap_r;
    assign o_cnt       = r_snap_cnt;

endmodule

`default_nettype wire

// ===== hw/rtl/rdbm_ctrl.sv =====
`default_nettype none

module rdbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_snap_full,
    input  logic              i_snap_mono,
    input  rdbm_pkg::t_dp_sts i_dp_sts,
    output rdbm_pkg::t_cmd    o_cmd
);

    import rdbm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_NORM  = 10'b0000000100,
        S_ITER  = 10'b0000001000,
        S_STORE = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_SCALE = 10'b0001000000,
        S_RECIP = 10'b0010000000,
        S_SAVE  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_sel   r_sel;
    t_sel   n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_CNT;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_snap_full) begin
                    n_sel   = SEL_CNT;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_dp_sts.norm_done) begin
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_dp_sts.iter_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_sel == SEL_CNT) begin
                    n_sel   = SEL_LEFT;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_SAVE;
            end
            S_SAVE: begin
                o_cmd.save = 1'b1;
                o_cmd.copy = i_snap_mono && (r_sel == SEL_LEFT);
                if (r_sel == SEL_LEFT && !i_snap_mono) begin
                    n_sel   = SEL_RIGHT;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_dp_sts.out_busy) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.release_snap = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rdbm_dpath.sv =====
`default_nettype none

module rdbm_dpath #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 47,
    parameter int CNT_W       = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rdbm_pkg::t_cmd             i_cmd,
    input  logic [SUM_W-1:0]           i_sum_l,
    input  logic [SUM_W-1:0]           i_sum_r,
    input  logic [CNT_W-1:0]           i_cnt,
    input  logic                       i_out_stall,
    output rdbm_pkg::t_dp_sts          o_sts,
    output logic                       o_valid,
    output logic [rdbm_pkg::LVL_W-1:0] o_left_level,
    output logic [rdbm_pkg::LVL_W-1:0] o_right_level
);

    import rdbm_pkg::*;

    localparam int LOG_W   = (SUM_W > MANT_W) ? SUM_W : MANT_W;
    localparam int SH_W    = $clog2(LOG_W);
    localparam int LOG_V_W = SH_W + LOG_FRAC_BITS;
    localparam int L_W     = LOG_V_W + 2;
    localparam int MP_W    = L_W + DB_W;
    localparam int DBM_W   = MP_W - DB_FRAC_SHIFT;
    localparam int N_W     = DBM_W + 2;
    localparam logic signed [L_W-1:0] LOG_OFS =
        L_W'((2 * (SAMPLE_BITS - 1)) * (2 ** LOG_FRAC_BITS));
    localparam logic [SH_W-1:0] MSB_TOP = SH_W'(LOG_W - 1);
    localparam logic [K_W-1:0]  K_LAST  = K_W'(LOG_FRAC_BITS - 1);

    logic [LOG_W-1:0]         opnd;
    logic                     opnd_zero;
    logic [2*MANT_W-1:0]      sq;
    logic [MANT_W:0]          sq_top;
    logic [LOG_V_W-1:0]       log_val;
    logic signed [L_W-1:0]    l_val;
    logic [L_W-1:0]           l_mag;
    logic [MP_W-1:0]          db_prod;
    logic signed [N_W-1:0]    db_s;
    logic signed [N_W-1:0]    n_val;
    logic [N_LO_W-1:0]        n_lo;
    logic [X_W-1:0]           x_val;
    logic [LVL_W-1:0]         lvl;

    logic [LOG_W-1:0]         r_norm;
    logic [SH_W-1:0]          r_shift;
    logic [MANT_W-1:0]        r_m;
    logic [LOG_FRAC_BITS-1:0] r_frac;
    logic [K_W-1:0]           r_k;
    logic [LOG_V_W-1:0]       r_lcnt;
    logic [LOG_V_W-1:0]       r_lsum;
    logic                     r_sum_zero;
    logic [DBM_W-1:0]         r_db_mag;
    logic                     r_db_neg;
    logic                     r_lo;
    logic                     r_hi;
    logic [Y_W-1:0]           r_y;
    logic [Q_W-1:0]           r_q;
    logic [LVL_W-1:0]         r_lvl_l;
    logic [LVL_W-1:0]         r_lvl_r;
    logic                     r_o_valid;
    logic [LVL_W-1:0]         r_o_left;
    logic [LVL_W-1:0]         r_o_right;

    always_comb begin
        case (i_cmd.sel)
            SEL_CNT:   opnd = LOG_W'(i_cnt);
            SEL_LEFT:  opnd = LOG_W'(i_sum_l);
            SEL_RIGHT: opnd = LOG_W'(i_sum_r);
            default:   opnd = '0;
        endcase
    end
    assign opnd_zero = (opnd == '0);

    assign sq      = r_m * r_m;
    assign sq_top  = sq[2*MANT_W-1 -: MANT_W+1];
    assign log_val = {MSB_TOP - r_shift, r_frac};

    assign l_val   = $signed({2'b00, r_lsum}) - $signed({2'b00, r_lcnt}) - LOG_OFS;
    assign l_mag   = l_val[L_W-1] ? L_W'(-l_val) : L_W'(l_val);
    assign db_prod = MP_W'(l_mag) * MP_W'(DB_PER_OCT);

    assign db_s  = $signed(N_W'(r_db_mag));
    assign n_val = (r_db_neg ? -db_s : db_s) + N_W'(DB_OFFSET);
    assign n_lo  = n_val[N_LO_W-1:0];
    assign x_val = {n_lo, LVL_W'(0)} - X_W'(n_lo);

    assign lvl = (r_sum_zero || r_lo) ? '0 :
                 r_hi ? '1 : r_q[RECIP_SHIFT +: LVL_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_norm  <= opnd_zero ? LOG_W'(1) : opnd;
            r_shift <= '0;
            if (i_cmd.sel != SEL_CNT) begin
                r_sum_zero <= opnd_zero;
            end
        end else if (i_cmd.norm) begin
            if (r_norm[LOG_W-1]) begin
                r_m    <= r_norm[LOG_W-1 -: MANT_W];
                r_frac <= '0;
                r_k    <= '0;
            end else if (r_norm[LOG_W-1 -: NORM_STEP] == '0) begin
                r_norm  <= r_norm << NORM_STEP;
                r_shift <= r_shift + SH_W'(NORM_STEP);
            end else begin
                r_norm  <= r_norm << 1;
                r_shift <= r_shift + 1'b1;
            end
        end else if (i_cmd.iter) begin
            r_m    <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            r_frac <= {r_frac[LOG_FRAC_BITS-2:0], sq_top[MANT_W]};
            r_k    <= r_k + 1'b1;
        end else if (i_cmd.store) begin
            if (i_cmd.sel == SEL_CNT) begin
                r_lcnt <= log_val;
            end else begin
                r_lsum <= log_val;
            end
        end else if (i_cmd.mul) begin
            r_db_mag <= db_prod[MP_W-1:DB_FRAC_SHIFT];
            r_db_neg <= l_val[L_W-1];
        end else if (i_cmd.scale) begin
            r_lo <= n_val[N_W-1] || (n_val == '0);
            r_hi <= !n_val[N_W-1] && (n_val >= N_W'(DB_SPAN));
            r_y  <= x_val[X_W-1 -: Y_W];
        end else if (i_cmd.recip) begin
            r_q <= Q_W'(r_y) * Q_W'(RECIP5);
        end else if (i_cmd.save) begin
            if (i_cmd.sel == SEL_RIGHT) begin
                r_lvl_r <= lvl;
            end else begin
                r_lvl_l <= lvl;
                if (i_cmd.copy) begin
                    r_lvl_r <= lvl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_left  <= r_lvl_l;
            r_o_right <= r_lvl_r;
        end
    end

    assign o_sts.norm_done = r_norm[LOG_W-1];
    assign o_sts.iter_last = (r_k == K_LAST);
    assign o_sts.out_busy  = r_o_valid && i_out_stall;

    assign o_valid       = r_o_valid;
    assign o_left_level  = r_o_left;
    assign o_right_level = r_o_right;

endmodule

`default_nettype wire
